@@ hw/rtl/triangle_check_perimeter_area_top_defines.svh @@
// assertion macros shared by the triangle check rtl
// no dependencies; included inside the modules that check themselves
`ifndef TRIANGLE_CHECK_PERIMETER_AREA_TOP_DEFINES_SVH
`define TRIANGLE_CHECK_PERIMETER_AREA_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TCPA_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tcpa check failed");

// next-cycle implication, off during reset
`define TCPA_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tcpa check failed");

`endif

@@ hw/rtl/tcpa_pkg.sv @@
// widths and the square-root cell payload for the triangle check block
// no dependencies
`default_nettype none

package tcpa_pkg;

  localparam int SIDE_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int PERIM_W = SIDE_W + 2;
  localparam int F_W     = SIDE_W + 1;          // b+c-a style factors
  localparam int M1_W    = PERIM_W + F_W;       // p * f1
  localparam int M2_W    = 2 * F_W;             // f2 * f3
  localparam int LO_W    = M2_W / 2;            // low split of m2
  localparam int HI_W    = M2_W - LO_W;
  localparam int PP_W    = M1_W + LO_W;         // partial product width
  localparam int X_W     = M1_W + M2_W;         // full heron product
  localparam int SHIFT   = 2 * FRAC_W + 4;
  localparam int AREA_W  = 23;
  localparam int RAD_W   = 2 * AREA_W;          // radicand bits kept
  localparam int ROOT_W  = AREA_W;
  localparam int REM_W   = ROOT_W + 2;

  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [PERIM_W-1:0] perim_t;
  typedef logic [AREA_W-1:0]  area_t;

  // one item travelling down the root chain
  typedef struct packed {
    logic              ok;
    perim_t            perim;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcpa_front.sv @@
// front pipeline: triangle test, perimeter and the heron product, four stages
// depends on tcpa_pkg
`default_nettype none

module tcpa_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           up_valid,
  input  wire tcpa_pkg::side_t side_a,
  input  wire tcpa_pkg::side_t side_b,
  input  wire tcpa_pkg::side_t side_c,
  output logic                up_take,
  output logic                dn_valid,
  output tcpa_pkg::sq_t       dn_data,
  input  wire logic           dn_take
);
  import tcpa_pkg::*;

  logic v1, v2, v3, v4;
  logic take1, take2, take3, take4;

  logic           ok1, ok2, ok3;
  perim_t         p1, p2, p3;
  logic [F_W-1:0] f1, f2, f3;
  logic [M1_W-1:0] m1;
  logic [M2_W-1:0] m2;
  logic [PP_W-1:0] pl, ph;
  sq_t            s4;

  logic [F_W-1:0]  sum_ab, sum_bc, sum_ac;
  logic            ok_c;
  perim_t          perim_c;
  logic [X_W-1:0]  x_c;
  logic            over_c;
  logic [RAD_W-1:0] rad_c;

  // a stage moves when it is empty or the next one moves
  assign take4   = !v4 || dn_take;
  assign take3   = !v3 || take4;
  assign take2   = !v2 || take3;
  assign take1   = !v1 || take2;
  assign up_take = take1;

  always_comb begin
    sum_ab  = {1'b0, side_a} + {1'b0, side_b};
    sum_bc  = {1'b0, side_b} + {1'b0, side_c};
    sum_ac  = {1'b0, side_a} + {1'b0, side_c};
    ok_c    = (sum_ab > {1'b0, side_c}) && (sum_bc > {1'b0, side_a}) &&
              (sum_ac > {1'b0, side_b});
    perim_c = {1'b0, sum_ab} + {2'b00, side_c};
  end

  // full product, only bits above the fixed-point scale reach the root
  always_comb begin
    x_c    = {{(X_W-PP_W){1'b0}}, pl} + {ph, {LO_W{1'b0}}};
    over_c = |x_c[X_W-1:SHIFT+RAD_W];
    if (!ok3) begin
      rad_c = '0;
    end else if (over_c) begin
      rad_c = '1;        // root of all ones is the saturated area
    end else begin
      rad_c = x_c[SHIFT+RAD_W-1:SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (take1) v1 <= up_valid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
      if (take4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && up_valid) begin
      ok1 <= ok_c;
      p1  <= perim_c;
      f1  <= sum_bc - {1'b0, side_a};
      f2  <= sum_ac - {1'b0, side_b};
      f3  <= sum_ab - {1'b0, side_c};
    end
    if (take2 && v1) begin
      ok2 <= ok1;
      p2  <= p1;
      m1  <= {{F_W{1'b0}}, p1} * {{PERIM_W{1'b0}}, f1};
      m2  <= {{F_W{1'b0}}, f2} * {{F_W{1'b0}}, f3};
    end
    if (take3 && v2) begin
      ok3 <= ok2;
      p3  <= p2;
      pl  <= {{LO_W{1'b0}}, m1} * {{M1_W{1'b0}}, m2[LO_W-1:0]};
      ph  <= {{HI_W{1'b0}}, m1} * {{M1_W{1'b0}}, m2[M2_W-1:LO_W]};
    end
    if (take4 && v3) begin
      s4.ok    <= ok3;
      s4.perim <= p3;
      s4.rad   <= rad_c;
      s4.rem   <= '0;
      s4.root  <= '0;
    end
  end

  assign dn_valid = v4;
  assign dn_data  = s4;

endmodule

`default_nettype wire

@@ hw/rtl/tcpa_cell.sv @@
// one square-root cell: brings down two radicand bits, settles one root bit
// depends on tcpa_pkg and the shared assertion macros
`default_nettype none

module tcpa_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  input  wire tcpa_pkg::sq_t up_data,
  output logic               up_take,
  output logic               dn_valid,
  output tcpa_pkg::sq_t      dn_data,
  input  wire logic          dn_take
);
  import tcpa_pkg::*;
  `include "triangle_check_perimeter_area_top_defines.svh"

  logic               valid;
  sq_t                data;
  logic [REM_W+1:0]   cur;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   diff;
  logic               ge;
  sq_t                data_next;

  assign up_take = !valid || dn_take;

  always_comb begin
    cur   = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
    trial = {2'b00, up_data.root, 2'b01};
    ge    = cur >= trial;
    diff  = cur - trial;
    data_next       = up_data;
    data_next.rad   = {up_data.rad[RAD_W-3:0], 2'b00};
    data_next.rem   = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
    data_next.root  = {up_data.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_take) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

  // remainder never exceeds twice the partial root
  `TCPA_ASSERT_NOW(a_rem_bound, clk, rst, valid, data.rem <= {1'b0, data.root, 1'b0})
  // a held item stays in the cell
  `TCPA_ASSERT_NEXT(a_hold, clk, rst, valid && !dn_take, valid && $stable(data))

endmodule

`default_nettype wire

@@ hw/rtl/triangle_check_perimeter_area_top.sv @@
// triangle check, perimeter and heron area on unsigned q8.8 sides
// depends on tcpa_pkg, tcpa_front, tcpa_cell and the shared assertion macros
//
//   channel  handshake              payload
//   input    tri_valid / tri_stall  side_a, side_b, side_c
//   output   res_valid / res_stall  is_triangle, perimeter, area
//
// one item per cycle unless res_stall holds the chain; 4 front stages, then one cell per root bit
// the 23-cell root chain follows the front; the front splits the 69-bit product
// reset clears only the valid bits of every stage
// a stall reaches back combinationally through the full stages, empty stages keep filling
// the last cell is the output register, so res_valid never looks at res_stall
`default_nettype none

module triangle_check_perimeter_area_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tri_valid,
  output logic                 tri_stall,
  input  wire tcpa_pkg::side_t side_a,
  input  wire tcpa_pkg::side_t side_b,
  input  wire tcpa_pkg::side_t side_c,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output logic                 is_triangle,
  output tcpa_pkg::perim_t     perimeter,
  output tcpa_pkg::area_t      area
);
  import tcpa_pkg::*;
  `include "triangle_check_perimeter_area_top_defines.svh"

  logic              front_take;
  logic [ROOT_W:0]   node_valid;
  logic [ROOT_W:0]   node_take;
  sq_t               node_data [ROOT_W+1];

  tcpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (tri_valid),
    .side_a   (side_a),
    .side_b   (side_b),
    .side_c   (side_c),
    .up_take  (front_take),
    .dn_valid (node_valid[0]),
    .dn_data  (node_data[0]),
    .dn_take  (node_take[0])
  );

  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    tcpa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (node_valid[k]),
      .up_data  (node_data[k]),
      .up_take  (node_take[k]),
      .dn_valid (node_valid[k+1]),
      .dn_data  (node_data[k+1]),
      .dn_take  (node_take[k+1])
    );
  end

  assign node_take[ROOT_W] = !res_stall;
  assign tri_stall         = !front_take;

  assign res_valid   = node_valid[ROOT_W];
  assign is_triangle = node_data[ROOT_W].ok;
  assign perimeter   = node_data[ROOT_W].perim;
  assign area        = node_data[ROOT_W].root;

  // an empty output register lets the whole chain move
  `TCPA_ASSERT_NOW(a_empty_accepts, clk, rst, !res_valid, !tri_stall)
  // a rejected triangle carries no area
  `TCPA_ASSERT_NOW(a_bad_zero_area, clk, rst, res_valid && !is_triangle, area == '0)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking bench for triangle_check_perimeter_area_top: directed table, then random sides
// depends on tcpa_pkg and the block's rtl; results checked against typed rows or a heron predictor
module tb_top;
  import tcpa_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES  = 200;
  localparam int WATCHDOG_MAX = 1000;
  localparam int TAIL_CYCLES  = 40;
  localparam area_t AREA_SAT  = '1;

  typedef struct packed {
    logic   ok;
    perim_t perim;
    area_t  area;
  } shape_t;

  // typed = 1 means the expected result is given in the row
  typedef struct packed {
    logic   typed;
    side_t  a;
    side_t  b;
    side_t  c;
    shape_t want;
  } dir_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   tri_valid = 1'b0;
  logic   tri_stall;
  side_t  side_a = '0;
  side_t  side_b = '0;
  side_t  side_c = '0;
  logic   res_valid;
  logic   res_stall = 1'b0;
  logic   is_triangle;
  perim_t perimeter;
  area_t  area;

  shape_t shapes_due [$];
  shape_t got;
  shape_t want;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  logic   calm = 1'b0;
  int     hold_req = 0;
  int     hold_served = 0;
  int     hold_left = 0;

  dir_row_t dir_rows [18] = '{
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, '{1'b0, 18'd0,      23'd0}},
    '{1'b1, 16'hFFFF, 16'h0000, 16'h0000, '{1'b0, 18'd65535,  23'd0}},
    '{1'b1, 16'h0000, 16'hFFFF, 16'h0000, '{1'b0, 18'd65535,  23'd0}},
    '{1'b1, 16'h0000, 16'h0000, 16'hFFFF, '{1'b0, 18'd65535,  23'd0}},
    '{1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, '{1'b0, 18'd131070, 23'd0}},
    '{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, '{1'b0, 18'd131070, 23'd0}},
    '{1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, '{1'b0, 18'd131070, 23'd0}},
    '{1'b1, 16'h0100, 16'h0100, 16'h0200, '{1'b0, 18'd1024,   23'd0}},
    '{1'b1, 16'h0100, 16'h0200, 16'h0100, '{1'b0, 18'd1024,   23'd0}},
    '{1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, '{1'b0, 18'd131070, 23'd0}},
    '{1'b1, 16'h0100, 16'h0100, 16'h0100, '{1'b1, 18'd768,    23'd110}},
    '{1'b1, 16'h0300, 16'h0400, 16'h0500, '{1'b1, 18'd3072,   23'd1536}},
    '{1'b1, 16'h0001, 16'h0001, 16'h0001, '{1'b1, 18'd3,      23'd0}},
    '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0},
    '{1'b0, 16'hFFFF, 16'hFFFF, 16'h0001, '0},
    '{1'b0, 16'h0001, 16'hFFFF, 16'hFFFF, '0},
    '{1'b0, 16'h8000, 16'h8000, 16'hFFFF, '0},
    '{1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, '0}
  };

  triangle_check_perimeter_area_top u_top (
    .clk         (clk),
    .rst         (rst),
    .tri_valid   (tri_valid),
    .tri_stall   (tri_stall),
    .side_a      (side_a),
    .side_b      (side_b),
    .side_c      (side_c),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .is_triangle (is_triangle),
    .perimeter   (perimeter),
    .area        (area)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor of the square root, one result bit at a time
  function automatic area_t root_floor(input logic [45:0] v);
    logic [23:0] root;
    logic [23:0] trial;
    root = '0;
    for (int i = AREA_W - 1; i >= 0; i--) begin
      trial = root | (24'd1 << i);
      if (64'(trial) * 64'(trial) <= 64'(v))
        root = trial;
    end
    return root[AREA_W-1:0];
  endfunction

  function automatic shape_t heron_predict(input side_t a, input side_t b, input side_t c);
    shape_t      r;
    logic [17:0] sa;
    logic [17:0] sb;
    logic [17:0] sc;
    logic [79:0] prod;
    sa = 18'(a);
    sb = 18'(b);
    sc = 18'(c);
    r.perim = sa + sb + sc;
    r.ok    = (sa + sb > sc) && (sb + sc > sa) && (sa + sc > sb);
    r.area  = '0;
    if (r.ok) begin
      // 4 * 4 * area^2 scaled by 2^(4*frac) -> drop 2*frac+4 bits before the root
      prod = 80'(r.perim) * 80'(sb + sc - sa) * 80'(sa + sc - sb) * 80'(sa + sb - sc);
      if (prod[79:SHIFT+RAD_W] != '0)
        r.area = AREA_SAT;
      else
        r.area = root_floor(prod[SHIFT+RAD_W-1:SHIFT]);
    end
    return r;
  endfunction

  task automatic offer_sides(input side_t a, input side_t b, input side_t c,
                             input shape_t expected);
    tri_valid <= 1'b1;
    side_a    <= a;
    side_b    <= b;
    side_c    <= c;
    do @(posedge clk); while (tri_stall);
    shapes_due = {shapes_due, expected};
  endtask

  task automatic wait_all_results();
    tri_valid <= 1'b0;
    do @(posedge clk); while (shapes_due.size() != 0);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < 14) begin
      tri_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic pick_sides(output side_t a, output side_t b, output side_t c);
    int    kind;
    int    lo;
    int    hi;
    side_t s0;
    side_t s1;
    side_t s2;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // well-formed triangle with random shape
      s0 = $urandom_range(1, 65535);
      s1 = $urandom_range(1, 65535);
      lo = (s0 > s1) ? int'(s0) - int'(s1) + 1 : int'(s1) - int'(s0) + 1;
      hi = int'(s0) + int'(s1) - 1;
      if (hi > 65535) hi = 65535;
      s2 = $urandom_range(lo, hi);
    end else if (kind < 65) begin
      s0 = $urandom_range(0, 15);
      s1 = $urandom_range(0, 15);
      s2 = $urandom_range(0, 15);
    end else if (kind < 75) begin
      // degenerate: one side equals the sum of the others
      s0 = $urandom_range(0, 65535);
      s1 = $urandom_range(0, 65535 - int'(s0));
      s2 = s0 + s1;
    end else begin
      s0 = $urandom_range(0, 65535);
      s1 = $urandom_range(0, 65535);
      s2 = $urandom_range(0, 65535);
    end
    case ($urandom_range(0, 2))
      0: begin a = s0; b = s1; c = s2; end
      1: begin a = s1; b = s2; c = s0; end
      default: begin a = s2; b = s0; c = s1; end
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_served) begin
      res_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      res_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      got = '{is_triangle, perimeter, area};
      if (shapes_due.size() == 0) begin
        $display("%0t: result with nothing expected: ok %0d perimeter %0d area %0d",
                 $time, got.ok, got.perim, got.area);
        mismatches++;
      end else begin
        want = shapes_due.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: is_triangle expected %0d actual %0d", $time, want.ok, got.ok);
          mismatches++;
        end
        if (got.perim !== want.perim) begin
          $display("%0t: perimeter expected %0d actual %0d", $time, want.perim, got.perim);
          mismatches++;
        end
        if (got.area !== want.area) begin
          $display("%0t: area expected %0d actual %0d", $time, want.area, got.area);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((tri_valid && !tri_stall) || (res_valid && !res_stall) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    side_t a;
    side_t b;
    side_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed)
        offer_sides(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].want);
      else
        offer_sides(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                    heron_predict(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c));
      sender_gap();
    end
    wait_all_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_req <= hold_req + 1;
      if (n == 900) wait_all_results();
      if (n == 1000) calm <= 1'b1;
      if (n == 1300) calm <= 1'b0;
      pick_sides(a, b, c);
      offer_sides(a, b, c, heron_predict(a, b, c));
      sender_gap();
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
